FILE: hw/rtl/lrukv_pkg.sv
// ---------------------------------------------------------------------------
// lrukv_pkg
// shared sizes, codes and types of the lru key-value cache
// ---------------------------------------------------------------------------
package lrukv_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int RANK_W  = IDX_W;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // operation codes
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // register index (word address bit)
    localparam logic REG_CAPACITY = 1'b0;

    // command to the recency table, all parts applied together
    typedef struct packed {
        logic             promote;   // move slot to most recent
        logic [IDX_W-1:0] slot;
        logic             insert;    // fill ins_slot as most recent
        logic [IDX_W-1:0] ins_slot;
        logic             evict;     // drop ev_slot first
        logic [IDX_W-1:0] ev_slot;
    } t_rank_cmd;

    // status from the recency table
    typedef struct packed {
        logic               scan_valid;
        logic [RANK_W-1:0]  scan_rank;
        logic               cmp_valid;
        logic [ENTRIES-1:0] valid;
        logic [CNT_W-1:0]   occupancy;
    } t_rank_stat;

    // capacity of zero acts as one, above the table size saturates
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        logic [CNT_W-1:0] c;
        if (cap == '0) begin
            c = CNT_W'(1);
        end else if (32'(cap) > ENTRIES) begin
            c = CNT_W'(ENTRIES);
        end else begin
            c = CNT_W'(cap);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/lrukv_rank.sv
// ---------------------------------------------------------------------------
// lrukv_rank
// valid bits, recency ranks and occupancy of the cache entries
// ---------------------------------------------------------------------------
module lrukv_rank (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [lrukv_pkg::IDX_W-1:0] i_scan_idx,
    input  logic [lrukv_pkg::IDX_W-1:0] i_cmp_idx,
    input  lrukv_pkg::t_rank_cmd       i_cmd,
    output lrukv_pkg::t_rank_stat      o_stat
);
    import lrukv_pkg::*;

    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [RANK_W-1:0]  r_rank [ENTRIES];
    logic [RANK_W-1:0]  n_rank [ENTRIES];
    logic [CNT_W-1:0]   r_occ, n_occ;
    logic [RANK_W-1:0]  pr_rank;
    logic               keep;

    assign pr_rank = r_rank[i_cmd.slot];

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_occ   = r_occ;
        keep    = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_cmd.promote) begin
                if (r_valid[i] && r_rank[i] < pr_rank) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
                if (IDX_W'(i) == i_cmd.slot) begin
                    n_rank[i] = '0;
                end
            end else if (i_cmd.insert || i_cmd.evict) begin
                keep = r_valid[i] && !(i_cmd.evict && IDX_W'(i) == i_cmd.ev_slot);
                if (keep && i_cmd.insert) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
                if (i_cmd.evict && IDX_W'(i) == i_cmd.ev_slot) begin
                    n_valid[i] = 1'b0;
                    n_rank[i]  = '0;
                end
                if (i_cmd.insert && IDX_W'(i) == i_cmd.ins_slot) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = '0;
                end
            end
        end
        if (i_cmd.evict && r_occ != '0) begin
            n_occ = n_occ - CNT_W'(1);
        end
        if (i_cmd.insert) begin
            n_occ = n_occ + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
            r_rank  <= n_rank;
        end
    end

    assign o_stat.scan_valid = r_valid[i_scan_idx];
    assign o_stat.scan_rank  = r_rank[i_scan_idx];
    assign o_stat.cmp_valid  = r_valid[i_cmp_idx];
    assign o_stat.valid      = r_valid;
    assign o_stat.occupancy  = r_occ;

endmodule

FILE: hw/rtl/lru_key_value_cache.sv
// ---------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value cache with least-recently-used replacement
// ---------------------------------------------------------------------------
// A request is accepted in the idle state. The scan state walks the key memory
// one entry per cycle through a single 32-bit comparator (the key memory's one
// read port sets this). A drain state covers the last registered read, an
// update state follows, and the done state loads the result register once the
// result side is free. s_axis_tready is high only between requests; a result
// may still wait in the output register while the next request is taken. tuser
// on the request side is the operation (0 get, 1 put); on the result side it is
// the hit flag. Capacity is written at address 0 over apb.
module lru_key_value_cache (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,  // [31:0] key, [63:32] value
    input  logic                          s_axis_tuser,  // [0] func
    // result
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // [31:0] read_value
    output logic                          m_axis_tuser,  // [0] hit
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lrukv_pkg::APB_AW-1:0]  paddr,
    input  logic [lrukv_pkg::APB_DW-1:0]  pwdata,
    output logic [lrukv_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import lrukv_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CAP_W-1:0]  r_cap;
    logic              r_func;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic              r_cmp_en;
    logic [KEY_W-1:0]  r_rd_key;
    logic [VAL_W-1:0]  r_rd_val;
    logic              r_hit;
    logic [IDX_W-1:0]  r_slot;
    logic              r_old_found;
    logic [IDX_W-1:0]  r_old;
    logic [RANK_W-1:0] r_old_rank;
    logic              r_free_found;
    logic [IDX_W-1:0]  r_free;
    logic              r_out_vld;
    logic              r_out_hit;
    logic [VAL_W-1:0]  r_out_val;

    logic [KEY_W-1:0]  key_mem [ENTRIES];
    logic [VAL_W-1:0]  val_mem [ENTRIES];

    t_rank_cmd         cmd;
    t_rank_stat        stat;
    logic              req_acc;
    logic              cfg_wr;
    logic              need_evict;
    logic              do_evict;
    logic              use_old;
    logic              out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY;
    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(r_cap) : '0;

    assign s_axis_tready = (r_state == S_IDLE);
    assign req_acc       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;

    // miss put: make room when full, the freed slot may be the lowest free one
    assign need_evict = stat.occupancy >= eff_cap(r_cap);
    assign do_evict   = need_evict && r_old_found;
    assign use_old    = do_evict && (!r_free_found || r_old < r_free);

    always_comb begin
        cmd          = '0;
        cmd.slot     = r_slot;
        cmd.ev_slot  = r_old;
        cmd.ins_slot = use_old ? r_old : r_free;
        if (r_state == S_UPDATE) begin
            if (r_hit) begin
                cmd.promote = 1'b1;
            end else if (r_func == FUNC_PUT) begin
                cmd.evict  = do_evict;
                cmd.insert = use_old || r_free_found;
            end
        end
    end

    lrukv_rank u_rank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_scan_idx (r_idx),
        .i_cmp_idx  (r_cmp_idx),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_acc) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_idx == IDX_W'(ENTRIES - 1)) n_state = S_DRAIN;
            end
            S_DRAIN:  n_state = S_UPDATE;
            S_UPDATE: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cap     <= CAP_RESET;
            r_cmp_en  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmp_en <= (r_state == S_SCAN);
            if (cfg_wr) r_cap <= pwdata[CAP_W-1:0];
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_func       <= s_axis_tuser;
            r_key        <= s_axis_tdata[KEY_W-1:0];
            r_val        <= s_axis_tdata[KEY_W +: VAL_W];
            r_idx        <= '0;
            r_hit        <= 1'b0;
            r_old_found  <= 1'b0;
            r_free_found <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            r_idx     <= r_idx + IDX_W'(1);
            r_cmp_idx <= r_idx;
            // oldest valid entry, first one wins on a tie
            if (stat.scan_valid && (!r_old_found || stat.scan_rank > r_old_rank)) begin
                r_old_found <= 1'b1;
                r_old       <= r_idx;
                r_old_rank  <= stat.scan_rank;
            end
            if (!stat.scan_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free       <= r_idx;
            end
        end
        // compare in the cycle after the key read
        if (r_cmp_en && stat.cmp_valid && r_rd_key == r_key && !r_hit) begin
            r_hit  <= 1'b1;
            r_slot <= r_cmp_idx;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_hit <= r_hit;
            if (r_func == FUNC_PUT) begin
                r_out_val <= '0;
            end else if (r_hit) begin
                r_out_val <= r_rd_val;
            end else begin
                r_out_val <= '1;
            end
        end
    end

    // key and value memories
    always_ff @(posedge i_clk) begin
        r_rd_key <= key_mem[r_idx];
        if (cmd.insert) begin
            key_mem[cmd.ins_slot] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_val <= val_mem[r_slot];
        if (cmd.insert) begin
            val_mem[cmd.ins_slot] <= r_val;
        end else if (cmd.promote && r_func == FUNC_PUT) begin
            val_mem[r_slot] <= r_val;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_hit;
    assign m_axis_tdata  = r_out_val;

`ifndef SYNTH
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(stat.valid) == 32'(stat.occupancy))
        else $error("occupancy does not match the valid entries");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_DONE))
        else $error("result appeared outside the done state");

    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.promote || cmd.insert || cmd.evict) |-> r_state == S_UPDATE)
        else $error("recency table changed outside the update cycle");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && !r_hit && r_func == FUNC_PUT) |=>
            32'(stat.occupancy) <= ENTRIES)
        else $error("occupancy exceeded the table size");
`endif

endmodule

FILE: test/tb_lru_key_value_cache.sv
// ---------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking bench for the LRU key-value cache. Get and put requests go in
// on the request stream. Every accepted request is run through a behavioral
// copy of the cache, which holds its own keys, values and recency ages. Each
// result is then checked against the oldest prediction. Capacity is written
// over APB between phases and read back. The run goes through the capacity
// extremes, lowering capacity below occupancy, and idle and stall patterns on
// both streams.
// ---------------------------------------------------------------------------
module tb_lru_key_value_cache;

    timeunit 1ns;
    timeprecision 1ps;

    import lrukv_pkg::*;

    localparam logic [APB_AW-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
    localparam int IDLE_LIMIT         = 2000;
    localparam int DRAIN_CYCLES       = 25;
    localparam int RANDOM_PER_SETTING = 156;
    localparam int POOL_SIZE          = 32;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } t_cache_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata;   // [31:0] key, [63:32] value
    logic                 s_axis_tuser;   // [0] func
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [31:0]          m_axis_tdata;   // [31:0] read_value
    logic                 m_axis_tuser;   // [0] hit
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // behavioral copy of the cache
    logic [KEY_W-1:0]     slot_key   [ENTRIES];
    logic [VAL_W-1:0]     slot_value [ENTRIES];
    logic                 slot_used  [ENTRIES];
    int unsigned          slot_age   [ENTRIES];
    int unsigned          fill_count;
    logic [CAP_W-1:0]     cap_reg;

    t_cache_result        expected_results [$];
    logic [KEY_W-1:0]     key_pool [POOL_SIZE];
    int                   error_count;
    int                   idle_cycles;
    int                   src_idle_pct;
    int                   dst_idle_pct;

    lru_key_value_cache u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---- cache behavior ----

    function automatic int unsigned capacity_in_use();
        int unsigned c;
        c = cap_reg;
        if (c == 0) begin
            c = 1;
        end else if (c > ENTRIES) begin
            c = ENTRIES;
        end
        return c;
    endfunction

    function automatic t_cache_result cache_access(input logic func,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [VAL_W-1:0] value);
        t_cache_result res;
        int            slot;
        int            victim;
        int            free_slot;
        int unsigned   old_age;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && slot_used[i] && slot_key[i] == key) begin
                slot = i;
            end
        end
        res.hit        = (slot >= 0);
        res.read_value = '0;
        if (slot >= 0) begin
            if (func == FUNC_GET) begin
                res.read_value = slot_value[slot];
            end else begin
                slot_value[slot] = value;
            end
            // entries more recent than this one age by one
            old_age = slot_age[slot];
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_used[i] && slot_age[i] < old_age) begin
                    slot_age[i]++;
                end
            end
            slot_age[slot] = 0;
        end else if (func == FUNC_GET) begin
            res.read_value = '1;
        end else begin
            if (fill_count >= capacity_in_use()) begin
                victim = -1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) begin
                        victim = i;
                    end
                end
                if (victim >= 0) begin
                    slot_used[victim] = 1'b0;
                    slot_age[victim]  = 0;
                    if (fill_count > 0) begin
                        fill_count--;
                    end
                end
            end
            free_slot = -1;
            for (int i = 0; i < ENTRIES; i++) begin
                if (free_slot < 0 && !slot_used[i]) begin
                    free_slot = i;
                end
            end
            if (free_slot >= 0) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_used[i]) begin
                        slot_age[i]++;
                    end
                end
                slot_key[free_slot]   = key;
                slot_value[free_slot] = value;
                slot_used[free_slot]  = 1'b1;
                slot_age[free_slot]   = 0;
                fill_count++;
            end
        end
        return res;
    endfunction

    // ---- stimulus helpers ----

    task automatic send_request(input logic func, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(cache_access(func, key, value));
    endtask

    task automatic drain_requests();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        logic [APB_DW-1:0] readback;
        drain_requests();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAPACITY;
        pwdata  <= APB_DW'(cap);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cap_reg = cap;
        // read back in a second transfer
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== APB_DW'(cap)) begin
            $display("%0t: capacity readback mismatch: expected %h actual %h",
                     $time, APB_DW'(cap), readback);
            error_count++;
        end
    endtask

    task automatic random_burst(input logic [CAP_W-1:0] cap);
        int unsigned      span;
        logic             func;
        logic [KEY_W-1:0] key;
        write_capacity(cap);
        // key pool a bit wider than capacity so that hits and evictions both happen
        span = capacity_in_use() + capacity_in_use() / 2 + 2;
        for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
            if ($urandom_range(99) < 85) begin
                key = key_pool[$urandom_range(span - 1)];
            end else begin
                key = $urandom();
            end
            func = ($urandom_range(99) < 45) ? FUNC_PUT : FUNC_GET;
            send_request(func, key, $urandom());
        end
    endtask

    // ---- tests ----

    task automatic test_basic_operations();
        send_request(FUNC_GET, 32'h0000_0000, 32'h1234_5678);   // get on an empty cache
        send_request(FUNC_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
        send_request(FUNC_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
        send_request(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);   // update in place
        send_request(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_GET, 32'h5A5A_A5A5, 32'hA5A5_5A5A);   // miss
        send_request(FUNC_PUT, 32'h0000_0001, 32'h0000_0000);
        send_request(FUNC_PUT, 32'h0000_0002, 32'h0000_0001);
    endtask

    task automatic test_capacity_corners();
        // lowered below occupancy: one eviction per insert, occupancy stays put
        write_capacity(CAP_W'(2));
        send_request(FUNC_PUT, 32'h0000_0003, 32'h0000_0033);
        send_request(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(FUNC_GET, 32'h0000_0003, 32'h0000_0000);
        // zero acts as one
        write_capacity(CAP_W'(0));
        send_request(FUNC_PUT, 32'h0000_0004, 32'h0000_0044);
        send_request(FUNC_PUT, 32'h0000_0005, 32'h0000_0055);
        send_request(FUNC_GET, 32'h0000_0004, 32'h0000_0000);
        // above the table size saturates
        write_capacity(CAP_W'(31));
        send_request(FUNC_PUT, 32'h0000_0006, 32'h0000_0066);
        send_request(FUNC_PUT, 32'h0000_0007, 32'h0000_0077);
        send_request(FUNC_GET, 32'h0000_0002, 32'h0000_0000);
        send_request(FUNC_GET, 32'h0000_0005, 32'h0000_0000);
    endtask

    task automatic test_random_traffic(input int src_pct, input int dst_pct,
                                       input logic [CAP_W-1:0] c0, input logic [CAP_W-1:0] c1,
                                       input logic [CAP_W-1:0] c2, input logic [CAP_W-1:0] c3);
        drain_requests();
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        random_burst(c0);
        random_burst(c1);
        random_burst(c2);
        random_burst(c3);
    endtask

    // ---- result checking ----

    always @(posedge i_clk) begin : check_results
        t_cache_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: expected none actual hit=%0b value=%h",
                         $time, m_axis_tuser, m_axis_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.hit) begin
                    $display("%0t: hit mismatch: expected %0b actual %0b",
                             $time, want.hit, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata !== want.read_value) begin
                    $display("%0t: read_value mismatch: expected %h actual %h",
                             $time, want.read_value, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_GET;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_count   = 0;
        idle_cycles   = 0;
        src_idle_pct  = 7;
        dst_idle_pct  = 71;
        fill_count    = 0;
        cap_reg       = CAP_RESET;
        for (int i = 0; i < ENTRIES; i++) begin
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_used[i]  = 1'b0;
            slot_age[i]   = 0;
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom();
        end
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_operations();
        test_capacity_corners();
        test_random_traffic(7, 71, CAP_W'(16), CAP_W'(1),
                            CAP_W'($urandom_range(15, 2)), CAP_W'(0));
        test_random_traffic(71, 7, CAP_W'(31), CAP_W'(3),
                            CAP_W'($urandom_range(15, 2)), CAP_W'(16));
        test_random_traffic(0, 0, CAP_W'(2), CAP_W'($urandom_range(15, 2)),
                            CAP_W'(1), CAP_W'(16));

        drain_requests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
